// File: rtl/elevation_grid_to_vertex_resampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the elevation grid resampler
// Clocked concurrent assertions with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ELEVATION_GRID_TO_VERTEX_RESAMPLER_ASSERT_SVH
`define ELEVATION_GRID_TO_VERTEX_RESAMPLER_ASSERT_SVH

// Property checked at every rising edge, off while reset is asserted.
`define EGVR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property violated");

// Same, with a message of the caller's choosing.
`define EGVR_ASSERT_MSG(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// File: rtl/egvr_pkg.sv
// ----------------------------------------------------------------------------
// egvr_pkg
// Types, codes and constants shared by the elevation grid resampler.
// ----------------------------------------------------------------------------
package egvr_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NODATA_VALUE = 2'd2;

    localparam logic [8:0]         GRID_COLUMNS_RESET = 9'd256;
    localparam logic [8:0]         GRID_ROWS_RESET    = 9'd256;
    localparam logic signed [31:0] NODATA_RESET       = -32'sd2304000;

    // 65535.0 with 8 fraction bits
    localparam logic signed [31:0] MIN_START = 32'sd16776960;

    // Commands
    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_RANGE      = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] cell_height;
        logic [8:0]         vertex_row;
        logic [8:0]         vertex_column;
    } egvr_item_t;

    typedef struct packed {
        logic signed [31:0] vertex_height;
        logic signed [31:0] lowest_height;
        logic [30:0]        highest_height;
        logic               saw_nodata;
        logic [1:0]         status;
    } egvr_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_FETCH,
        ST_DRAIN,
        ST_RESULT
    } egvr_state_t;

    typedef struct packed {
        logic       accepting;
        logic       base_en;
        logic       rd_en;
        logic [1:0] step;
        logic       drain;
        logic       res_ready;
    } egvr_ctrl_t;

endpackage

// File: rtl/egvr_ram.sv
// ----------------------------------------------------------------------------
// egvr_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module egvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/egvr_fsm.sv
// ----------------------------------------------------------------------------
// egvr_fsm
// Sequencer: accepts items, steps the cell fetches of a vertex read and
// hands each result to the output register.
// ----------------------------------------------------------------------------
module egvr_fsm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic                  needs_fetch,
    input  logic                  quad,
    input  logic                  slot_free,
    output egvr_pkg::egvr_ctrl_t  ctrl
);

    egvr_pkg::egvr_state_t state_reg;
    egvr_pkg::egvr_state_t state_next;
    logic [1:0]            step_reg;
    logic [1:0]            step_next;
    logic [1:0]            last_step;

    assign last_step = quad ? 2'd3 : 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= egvr_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            egvr_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    state_next = needs_fetch ? egvr_pkg::ST_BASE : egvr_pkg::ST_RESULT;
                end
            end
            egvr_pkg::ST_BASE:
            begin
                state_next = egvr_pkg::ST_FETCH;
                step_next  = '0;
            end
            egvr_pkg::ST_FETCH:
            begin
                if (step_reg == last_step)
                begin
                    state_next = egvr_pkg::ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
            egvr_pkg::ST_DRAIN:
            begin
                state_next = egvr_pkg::ST_RESULT;
            end
            egvr_pkg::ST_RESULT:
            begin
                // hand over the result; a new item may enter in the same cycle
                if (slot_free)
                begin
                    if (fire)
                    begin
                        state_next = needs_fetch ? egvr_pkg::ST_BASE
                                                 : egvr_pkg::ST_RESULT;
                    end
                    else
                    begin
                        state_next = egvr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = egvr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            egvr_pkg::ST_IDLE:
            begin
                ctrl.accepting = 1'b1;
            end
            egvr_pkg::ST_BASE:
            begin
                ctrl.base_en = 1'b1;
            end
            egvr_pkg::ST_FETCH:
            begin
                ctrl.rd_en = 1'b1;
                ctrl.step  = step_reg;
            end
            egvr_pkg::ST_DRAIN:
            begin
                ctrl.drain = 1'b1;
            end
            egvr_pkg::ST_RESULT:
            begin
                ctrl.res_ready = 1'b1;
                ctrl.accepting = slot_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// File: rtl/elevation_grid_to_vertex_resampler.sv
// ----------------------------------------------------------------------------
// elevation_grid_to_vertex_resampler
// Loads a grid of cell heights, tracks min/max and answers vertex reads.
// ----------------------------------------------------------------------------
// Restart, load and unused commands can follow one another every cycle while
// the output register is not stalled. A vertex read averages the cells around
// it: four for an inner vertex, two for an edge vertex; a corner is answered
// without a fetch. The cells sit in one single-port RAM with a registered
// read, so a read fetches one cell per cycle after a base-address step.
// Results go out through a one-entry output register; the next item is
// taken while a result waits there. The cell RAM needs no clearing after
// reset: a read is only answered once the whole grid has been loaded.
// Heights are signed fixed point with 8 fraction bits.
module elevation_grid_to_vertex_resampler #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256,
    parameter int HEIGHT_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  egvr_pkg::egvr_item_t                 item,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    output egvr_pkg::egvr_result_t               result,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    input  logic                                 cfg_write,
    input  logic [egvr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [egvr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CI_W   = $clog2(MAX_COLUMNS);
    localparam int RI_W   = $clog2(MAX_ROWS);
    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int HW     = HEIGHT_BITS;
    localparam int VW     = (HEIGHT_BITS > 32) ? HEIGHT_BITS : 32;
    localparam int SW     = VW + 2;

    // configuration
    logic [8:0]         cols_cfg_reg;
    logic [8:0]         rows_cfg_reg;
    logic signed [31:0] nodata_cfg_reg;

    // grid state
    logic [POS_W-1:0]     pos_reg;
    logic signed [VW-1:0] min_reg;
    logic signed [VW-1:0] max_reg;
    logic                 seen_reg;

    // read datapath
    logic [RI_W-1:0]      r0_reg;
    logic [CI_W-1:0]      c0_reg;
    logic                 quad_reg;
    logic                 rstep_reg;
    logic                 cstep_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic                 pend_reg;
    logic signed [SW-1:0] acc_reg;

    egvr_pkg::egvr_result_t res_reg;
    egvr_pkg::egvr_result_t out_reg;
    logic                   out_valid_reg;

    egvr_pkg::egvr_ctrl_t   ctrl;
    egvr_pkg::egvr_result_t res_now;

    logic [COL_W-1:0]     cols;
    logic [ROW_W-1:0]     rows;
    logic [POS_W-1:0]     total;
    logic [HW-1:0]        nd_st;
    logic [HW-1:0]        h_st;
    logic signed [VW-1:0] h_val;
    logic                 fire;
    logic                 slot_free;
    logic                 load_ok;
    logic                 is_nd;
    logic                 complete;
    logic                 out_of_range;
    logic                 ri;
    logic                 ci;
    logic                 needs_fetch;
    logic [31:0]          i_w;
    logic [31:0]          j_w;
    logic [31:0]          rows_w;
    logic [31:0]          cols_w;
    logic [31:0]          r0_w;
    logic [31:0]          c0_w;
    logic [RI_W+COL_W-1:0] prod;
    logic                 row_bit;
    logic                 col_bit;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 mem_we;
    logic [HW-1:0]        mem_rdata;
    logic signed [VW-1:0] cell_val;
    logic signed [SW-1:0] acc_sum;
    logic signed [SW-1:0] vh_full;
    logic                 min_upd;
    logic                 max_upd;

    // effective grid size
    always_comb
    begin
        if (cols_cfg_reg == '0)
        begin
            cols = COL_W'(1);
        end
        else if (32'(cols_cfg_reg) > 32'(MAX_COLUMNS))
        begin
            cols = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = COL_W'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0)
        begin
            rows = ROW_W'(1);
        end
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS))
        begin
            rows = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows = ROW_W'(rows_cfg_reg);
        end
    end

    assign total = POS_W'(cols) * POS_W'(rows);

    assign nd_st = HW'($signed(nodata_cfg_reg));
    assign h_st  = HW'($signed(item.cell_height));
    assign h_val = VW'($signed(h_st));

    assign slot_free = !out_valid_reg || !result_stall;
    assign fire      = item_valid && ctrl.accepting;

    // load checks
    assign load_ok = pos_reg < total;
    assign is_nd   = h_st == nd_st;
    assign min_upd = !is_nd && (h_val < min_reg);
    assign max_upd = !is_nd && (h_val > max_reg);

    // read checks and first cell of the neighbourhood
    assign i_w    = 32'(item.vertex_row);
    assign j_w    = 32'(item.vertex_column);
    assign rows_w = 32'(rows);
    assign cols_w = 32'(cols);

    assign complete     = pos_reg >= total;
    assign out_of_range = (i_w > rows_w) || (j_w > cols_w);
    assign ri           = (i_w != '0) && (i_w < rows_w);
    assign ci           = (j_w != '0) && (j_w < cols_w);
    assign needs_fetch  = (item.command == egvr_pkg::CMD_READ) && complete
                          && !out_of_range && (ri || ci);

    always_comb
    begin
        if (ri)
        begin
            r0_w = i_w - 32'd1;
        end
        else
        begin
            r0_w = (i_w == '0) ? '0 : rows_w - 32'd1;
        end
        if (ci)
        begin
            c0_w = j_w - 32'd1;
        end
        else
        begin
            c0_w = (j_w == '0) ? '0 : cols_w - 32'd1;
        end
    end

    // result of an item that needs no cell fetch, built from the state after the transfer
    always_comb
    begin
        res_now                = '0;
        res_now.vertex_height  = '0;
        res_now.lowest_height  = min_reg[31:0];
        res_now.highest_height = max_reg[30:0];
        res_now.saw_nodata     = seen_reg;
        res_now.status         = egvr_pkg::STATUS_OK;
        case (item.command)
            egvr_pkg::CMD_RESTART:
            begin
                res_now.lowest_height  = egvr_pkg::MIN_START;
                res_now.highest_height = '0;
                res_now.saw_nodata     = 1'b0;
            end
            egvr_pkg::CMD_LOAD:
            begin
                if (!load_ok)
                begin
                    res_now.status = egvr_pkg::STATUS_RANGE;
                end
                else if (is_nd)
                begin
                    res_now.saw_nodata = 1'b1;
                end
                else
                begin
                    if (min_upd)
                    begin
                        res_now.lowest_height = h_val[31:0];
                    end
                    if (max_upd)
                    begin
                        res_now.highest_height = h_val[30:0];
                    end
                end
            end
            egvr_pkg::CMD_READ:
            begin
                if (!complete)
                begin
                    res_now.status = egvr_pkg::STATUS_INCOMPLETE;
                end
                else if (out_of_range)
                begin
                    res_now.status = egvr_pkg::STATUS_RANGE;
                end
            end
            default:
            begin
                res_now.status = egvr_pkg::STATUS_OK;
            end
        endcase
    end

    // cell addressing: base, then +1 column and/or +1 row
    assign prod    = r0_reg * cols;
    assign row_bit = rstep_reg && (cstep_reg ? ctrl.step[1] : ctrl.step[0]);
    assign col_bit = cstep_reg && ctrl.step[0];
    assign rd_addr = base_reg + (row_bit ? ADDR_W'(cols) : '0) + ADDR_W'(col_bit);

    assign mem_we   = fire && (item.command == egvr_pkg::CMD_LOAD) && load_ok;
    assign mem_addr = ctrl.rd_en ? rd_addr : pos_reg[ADDR_W-1:0];

    egvr_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (h_st),
        .rdata (mem_rdata)
    );

    // no-data cells count as the running minimum
    assign cell_val = (mem_rdata == nd_st) ? min_reg : VW'($signed(mem_rdata));
    assign acc_sum  = acc_reg + SW'(cell_val);
    assign vh_full  = quad_reg ? (acc_sum >>> 2) : (acc_sum >>> 1);

    egvr_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .needs_fetch (needs_fetch),
        .quad        (quad_reg),
        .slot_free   (slot_free),
        .ctrl        (ctrl)
    );

    // configuration and grid state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg   <= egvr_pkg::GRID_COLUMNS_RESET;
            rows_cfg_reg   <= egvr_pkg::GRID_ROWS_RESET;
            nodata_cfg_reg <= egvr_pkg::NODATA_RESET;
            pos_reg        <= '0;
            min_reg        <= VW'(egvr_pkg::MIN_START);
            max_reg        <= '0;
            seen_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    egvr_pkg::CFG_GRID_COLUMNS: cols_cfg_reg   <= cfg_data[8:0];
                    egvr_pkg::CFG_GRID_ROWS:    rows_cfg_reg   <= cfg_data[8:0];
                    egvr_pkg::CFG_NODATA_VALUE: nodata_cfg_reg <= $signed(cfg_data);
                    default:                    cols_cfg_reg   <= cols_cfg_reg;
                endcase
            end

            if (fire)
            begin
                case (item.command)
                    egvr_pkg::CMD_RESTART:
                    begin
                        pos_reg  <= '0;
                        min_reg  <= VW'(egvr_pkg::MIN_START);
                        max_reg  <= '0;
                        seen_reg <= 1'b0;
                    end
                    egvr_pkg::CMD_LOAD:
                    begin
                        if (load_ok)
                        begin
                            pos_reg <= pos_reg + POS_W'(1);
                            if (is_nd)
                            begin
                                seen_reg <= 1'b1;
                            end
                            if (min_upd)
                            begin
                                min_reg <= h_val;
                            end
                            if (max_upd)
                            begin
                                max_reg <= h_val;
                            end
                        end
                    end
                    default:
                    begin
                        seen_reg <= seen_reg;
                    end
                endcase
            end

            pend_reg <= ctrl.rd_en;

            if (ctrl.res_ready && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg   <= res_now;
            r0_reg    <= RI_W'(r0_w);
            c0_reg    <= CI_W'(c0_w);
            quad_reg  <= ri && ci;
            rstep_reg <= ri;
            cstep_reg <= ci;
        end

        if (ctrl.base_en)
        begin
            base_reg <= ADDR_W'(prod) + ADDR_W'(c0_reg);
            acc_reg  <= '0;
        end
        else if (pend_reg && !ctrl.drain)
        begin
            acc_reg <= acc_sum;
        end

        // last cell arrives: finish the floored mean
        if (ctrl.drain)
        begin
            res_reg.vertex_height <= vh_full[31:0];
            res_reg.status        <= egvr_pkg::STATUS_OK;
        end

        if (ctrl.res_ready && slot_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign item_stall   = !ctrl.accepting;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

// File: rtl/egvr_checker.sv
// ----------------------------------------------------------------------------
// egvr_checker
// Port-level checks on the resampler's result channel.
// ----------------------------------------------------------------------------
`include "elevation_grid_to_vertex_resampler_assert.svh"

module egvr_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  egvr_pkg::egvr_result_t result
);

    // hold a stalled result
    `EGVR_ASSERT(a_result_held, clk, rst_n, result_valid && result_stall |=> result_valid)
    `EGVR_ASSERT(a_result_stable, clk, rst_n, result_valid && result_stall |=> $stable(result))

    // a failed step never carries a height
    `EGVR_ASSERT_MSG(a_fail_zero_height, clk, rst_n,
        result_valid && (result.status != egvr_pkg::STATUS_OK) |->
        (result.vertex_height == '0), "failed step returned a vertex height")

    // the no-data flag only drops on restart, which also resets min and max
    `EGVR_ASSERT_MSG(a_flag_clear_on_restart, clk, rst_n,
        $past(result_valid && !result_stall && result.saw_nodata) && result_valid &&
        !result.saw_nodata |->
        (result.highest_height == '0) && (result.lowest_height == egvr_pkg::MIN_START),
        "no-data flag cleared without restart")

endmodule

bind elevation_grid_to_vertex_resampler egvr_checker u_egvr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
